>>> sv/assert_macros.svh
// assertion macros used by the pid controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/pcm_pkg.sv
// widths and constants shared by the pid controller files
package pcm_pkg;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int GAIN_W = 24;
    localparam int LIM_W  = 31;
    localparam int WGT_W  = FRAC_W + 1;
    localparam int WIDE_W = 48;
    localparam int ACC_W  = 72;
    localparam int CNT_W  = 5;
endpackage

>>> sv/pcm_div.sv
// restoring divider for the integral ramp weight, one quotient bit a cycle
module pcm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pcm_pkg::DATA_W-1:0]  i_num,
    input  logic [pcm_pkg::LIM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [pcm_pkg::WGT_W-1:0]   o_quot
);
    import pcm_pkg::*;

    logic [DATA_W-1:0] r_rem, n_rem;
    logic [LIM_W-1:0]  r_den;
    logic [WGT_W-1:0]  r_quot, n_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] kept;

    // trial subtract and shift
    always_comb begin
        diff   = {1'b0, r_rem} - {2'b0, r_den};
        ge     = !diff[DATA_W];
        kept   = ge ? diff[DATA_W-1:0] : r_rem;
        n_rem  = {kept[DATA_W-2:0], 1'b0};
        n_quot = {r_quot[WGT_W-2:0], ge};
    end

    // bit counter, done is registered together with the last quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(WGT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> sv/pid_controller_modes.sv
// pid controller top level: six control laws over one shared multiplier
// an item goes from acceptance through S_PREP, S_DIV when the ramp weight needs the division,
//   the products of its terms and S_WB
// one item at a time: a new setpoint is taken only in S_IDLE; a result not yet taken holds write-back
// each product runs through S_MLO, S_MHI and S_MFIN on the 24x24 multiplier
// reset (synchronous, active low) clears the state and loads the default registers
`include "assert_macros.svh"
module pid_controller_modes (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [pcm_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [pcm_pkg::DATA_W-1:0]  s_axis_tdata,   // setpoint
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [pcm_pkg::DATA_W-1:0]  m_axis_tdata,   // drive
    output logic                        m_axis_tuser    // saturated
);
    import pcm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_DIV = 3'd2, S_MLO = 3'd3,
                           S_MHI = 3'd4, S_MFIN = 3'd5, S_WB = 3'd6;
    localparam logic [2:0] REG_MODE = 3'd0, REG_GP = 3'd1, REG_GI = 3'd2, REG_GD = 3'd3,
                           REG_UB = 3'd4, REG_LB = 3'd5, REG_SL = 3'd6, REG_FL = 3'd7;
    localparam logic [2:0] M_POS = 3'd0, M_INC = 3'd1, M_SEP = 3'd2, M_AW = 3'd3,
                           M_RAMP = 3'd4, M_ALL = 3'd5;
    localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << FRAC_W;

    // configuration
    logic [2:0]        r_mode;
    logic [GAIN_W-1:0] r_gp, r_gi, r_gd;
    logic [DATA_W-1:0] r_ub, r_lb;
    logic [LIM_W-1:0]  r_sl, r_fl;

    // controller state and working registers
    logic [DATA_W-1:0] r_last, r_integral, r_pe, r_ebp, r_err, r_abs;
    logic [2:0]        r_state;
    logic [1:0]        r_term;
    logic              r_inc, r_sat;
    logic [WGT_W-1:0]  r_w;
    logic [WIDE_W-1:0] r_sum, r_mag;
    logic              r_mneg;
    logic [ACC_W-1:0]  r_acc;
    logic              r_out_valid, r_out_sat;
    logic [DATA_W-1:0] r_out_data;

    function automatic logic [WIDE_W-1:0] sx(input logic [DATA_W-1:0] v);
        sx = {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic clip_hit(input logic [WIDE_W-1:0] v);
        clip_hit = (v[WIDE_W-1:DATA_W-1] != '0) && (v[WIDE_W-1:DATA_W-1] != '1);
    endfunction

    function automatic logic [DATA_W-1:0] clip(input logic [WIDE_W-1:0] v);
        if (!clip_hit(v)) begin
            clip = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            clip = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            clip = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // error of the arriving item
    logic [WIDE_W-1:0] err_wide;
    logic [DATA_W-1:0] err_now;
    always_comb begin
        err_wide = sx(s_axis_tdata) - sx(r_last);
        err_now  = clip(err_wide);
    end

    // mode decode and integral decision
    logic [2:0]        m_eff;
    logic              is_inc, f_sep, f_ramp, f_aw, too_big, in_ramp, accum;
    logic [DATA_W-1:0] den;
    logic              need_div;
    logic [WIDE_W-1:0] integ_wide;
    always_comb begin
        m_eff    = (r_mode > M_ALL) ? M_ALL : r_mode;
        is_inc   = (m_eff == M_INC);
        f_sep    = (m_eff >= M_SEP);
        f_ramp   = (m_eff == M_RAMP) || (m_eff == M_ALL);
        f_aw     = (m_eff == M_AW) || (m_eff == M_ALL);
        too_big  = f_sep && (r_abs > {1'b0, r_sl});
        in_ramp  = !too_big && f_ramp && (r_abs >= {1'b0, r_fl});
        den      = {1'b0, r_sl} - {1'b0, r_fl};
        need_div = in_ramp && (den != '0);
        accum    = !too_big;
        if (accum && f_aw) begin
            if ($signed(r_last) > $signed(r_ub)) begin
                accum = r_err[DATA_W-1];
            end else if ($signed(r_last) < $signed(r_lb)) begin
                accum = !r_err[DATA_W-1] && (r_err != '0);
            end
        end
        integ_wide = sx(r_integral) + sx(r_err);
    end

    // shared multiplier and product result
    logic [GAIN_W-1:0]          mul_a, mul_b;
    logic [2*GAIN_W-1:0]        mul_p;
    logic [WIDE_W-1:0]          prod_mag, prod_s;
    always_comb begin
        mul_a    = (r_state == S_MHI) ? r_mag[2*GAIN_W-1:GAIN_W] : r_mag[GAIN_W-1:0];
        mul_p    = mul_a * mul_b;
        prod_mag = r_acc[FRAC_W +: WIDE_W];
        prod_s   = r_mneg ? (WIDE_W'(0) - prod_mag) : prod_mag;
    end

    // operand for the next product
    logic [1:0]        sel_term;
    logic [WIDE_W-1:0] op_val;
    logic [GAIN_W-1:0] op_gain, r_gain;
    logic              t_add, t_last, inc_sel;
    always_comb begin
        sel_term = (r_state == S_MFIN) ? r_term + 2'd1 : 2'd0;
        // the law of the item is only registered at the end of preparation
        inc_sel  = (r_state == S_PREP) ? is_inc : r_inc;
        op_val   = sx(r_err);
        op_gain  = r_gp;
        if (inc_sel) begin
            case (sel_term)
                2'd0: begin op_val = sx(r_err) - sx(r_ebp); op_gain = r_gp; end
                2'd1: begin op_val = sx(r_err); op_gain = r_gi; end
                2'd2: begin
                    op_val  = sx(r_err) - (sx(r_ebp) << 1) + sx(r_pe);
                    op_gain = r_gd;
                end
                default: begin op_val = sx(r_err); op_gain = r_gd; end
            endcase
        end else begin
            case (sel_term)
                2'd0: begin op_val = sx(r_err); op_gain = r_gp; end
                2'd1: begin op_val = sx(r_integral); op_gain = r_gi; end
                2'd2: begin op_val = prod_s; op_gain = GAIN_W'(r_w); end
                default: begin op_val = sx(r_err) - sx(r_pe); op_gain = r_gd; end
            endcase
        end
        t_add  = r_inc || (r_term != 2'd1);
        t_last = r_inc ? (r_term == 2'd2) : (r_term == 2'd3);
        mul_b  = r_gain;
    end

    logic              div_start, div_done;
    logic [WGT_W-1:0]  div_quot;
    assign div_start = (r_state == S_PREP) && need_div;

    pcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_abs <= {1'b0, r_sl} ? {1'b0, r_sl} - r_abs : '0),
        .i_den   (den[LIM_W-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_ALL;
            r_gp   <= GAIN_W'(13107);
            r_gi   <= GAIN_W'(13107);
            r_gd   <= GAIN_W'(13107);
            r_ub   <= DATA_W'(26214400);
            r_lb   <= DATA_W'(-13107200);
            r_sl   <= LIM_W'(13107200);
            r_fl   <= LIM_W'(11796480);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE: r_mode <= i_cfg_data[2:0];
                REG_GP:   r_gp   <= i_cfg_data[GAIN_W-1:0];
                REG_GI:   r_gi   <= i_cfg_data[GAIN_W-1:0];
                REG_GD:   r_gd   <= i_cfg_data[GAIN_W-1:0];
                REG_UB:   r_ub   <= i_cfg_data;
                REG_LB:   r_lb   <= i_cfg_data;
                REG_SL:   r_sl   <= i_cfg_data[LIM_W-1:0];
                REG_FL:   r_fl   <= i_cfg_data[LIM_W-1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // sequencer
    logic [WIDE_W-1:0] op_mag;
    assign op_mag = op_val[WIDE_W-1] ? (WIDE_W'(0) - op_val) : op_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_integral  <= '0;
            r_pe        <= '0;
            r_ebp       <= '0;
            r_out_valid <= 1'b0;
            r_term      <= '0;
        end else begin
            // result taken; write-back refills the output register itself
            if (m_axis_tvalid && m_axis_tready && r_state != S_WB) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err   <= err_now;
                        r_abs   <= err_now[DATA_W-1] ? DATA_W'(0) - err_now : err_now;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_inc  <= is_inc;
                    r_sat  <= !is_inc && accum && clip_hit(integ_wide);
                    r_sum  <= is_inc ? sx(r_last) : '0;
                    r_w    <= too_big ? '0 : W_ONE;
                    r_term <= 2'd0;
                    if (!is_inc && accum) begin
                        r_integral <= clip(integ_wide);
                    end
                    r_state <= need_div ? S_DIV : S_MLO;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_w     <= div_quot;
                        r_state <= S_MLO;
                    end
                end
                S_MLO: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_acc   <= r_acc + (ACC_W'(mul_p) << GAIN_W);
                    r_state <= S_MFIN;
                end
                S_MFIN: begin
                    if (t_add) begin
                        r_sum <= r_sum + prod_s;
                    end
                    r_term  <= r_term + 2'd1;
                    r_state <= t_last ? S_WB : S_MLO;
                end
                S_WB: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_last      <= clip(r_sum);
                        r_pe        <= r_inc ? r_ebp : r_err;
                        if (r_inc) begin
                            r_ebp <= r_err;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // multiplier operands and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP || r_state == S_MFIN) begin
            r_mag  <= op_mag;
            r_mneg <= op_val[WIDE_W-1];
            r_gain <= op_gain;
        end
        if (r_state == S_WB && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= clip(r_sum);
            r_out_sat  <= r_sat || clip_hit(r_sum);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    `ASSERT_HOLDS(a_div_in_wait, i_clk, i_rst_n, !div_done || r_state == S_DIV, "divider done outside wait")
    `ASSERT_NEXT(a_accept_prep, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == S_PREP, "accepted item not prepared")
    `ASSERT_NEXT(a_inc_keeps_int, i_clk, i_rst_n, r_state == S_PREP && is_inc, $stable(r_integral), "incremental law changed integral")
    `ASSERT_HOLDS(a_inc_terms, i_clk, i_rst_n, !(r_state == S_MLO && r_inc) || r_term != 2'd3, "incremental law ran a fourth product")
endmodule

>>> tb/tb_pid_controller_modes.sv
// self-checking testbench for the pid controller with selectable control laws
module tb_pid_controller_modes;
    import pcm_pkg::*;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_UPPER     = 3'd4,
        REG_LOWER     = 3'd5,
        REG_SEP_LIMIT = 3'd6,
        REG_FULL_LIM  = 3'd7
    } t_reg_idx;

    // control law codes
    localparam logic [2:0] LAW_POSITIONAL  = 3'd0;
    localparam logic [2:0] LAW_INCREMENTAL = 3'd1;
    localparam logic [2:0] LAW_SEPARATION  = 3'd2;
    localparam logic [2:0] LAW_ANTIWINDUP  = 3'd3;
    localparam logic [2:0] LAW_RAMP        = 3'd4;
    localparam logic [2:0] LAW_ALL         = 3'd5;
    localparam logic [2:0] LAW_SPARE_A     = 3'd6;
    localparam logic [2:0] LAW_SPARE_B     = 3'd7;

    localparam int    SETTLE_CYCLES = 40;
    localparam int    CYCLE_LIMIT   = 2000000;
    localparam int    PHASES        = 12;
    localparam int    PHASE_ITEMS   = 100;
    localparam longint DMAX         = 64'sd2147483647;
    localparam longint DMIN         = -64'sd2147483648;
    localparam longint unsigned PRODUCT_CAP = 64'h1 << 61;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              sat;
    } t_drive;

    // one directed row: either a register write or a setpoint
    typedef struct {
        bit                is_cfg;
        t_reg_idx          idx;
        logic [DATA_W-1:0] value;
        bit                typed;
        t_drive            typed_res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;     // setpoint
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;          // drive
    logic              m_axis_tuser;          // saturated

    pid_controller_modes dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // controller copy: registers and loop state
    logic [2:0]      law;
    longint unsigned kp, ki, kd;
    longint          upper_bnd, lower_bnd, sep_lim, full_lim;
    longint          last_drive, integ, err_prev, err_prev2;

    t_drive drive_q[$];
    int     idle_in = 0;
    int     idle_out = 0;
    int     errors = 0;
    int     cycles = 0;

    function automatic longint clip_word(longint v, inout bit hit);
        if (v > DMAX) begin
            hit = 1'b1;
            return DMAX;
        end
        if (v < DMIN) begin
            hit = 1'b1;
            return DMIN;
        end
        return v;
    endfunction

    // sign-magnitude fixed point product, truncated toward zero and capped
    function automatic longint scale(longint v, longint unsigned g);
        bit neg;
        longint unsigned mag, hi, lo, t, r;
        neg = v < 0;
        mag = neg ? 64'd0 - 64'(v) : 64'(v);
        g = g & 64'h1ff_ffff;
        if (mag > PRODUCT_CAP) mag = PRODUCT_CAP;
        hi = mag >> 24;
        lo = mag & 64'hff_ffff;
        t = hi * g;
        if (t > (PRODUCT_CAP >> 8))
            r = PRODUCT_CAP;
        else
            r = (t << 8) + ((lo * g) >> FRAC_W);
        if (r > PRODUCT_CAP) r = PRODUCT_CAP;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic void load_defaults();
        law = LAW_ALL;
        kp = 13107;
        ki = 13107;
        kd = 13107;
        upper_bnd = 26214400;
        lower_bnd = -13107200;
        sep_lim = 13107200;
        full_lim = 11796480;
        last_drive = 0;
        integ = 0;
        err_prev = 0;
        err_prev2 = 0;
    endfunction

    function automatic void shadow_reg(t_reg_idx idx, logic [DATA_W-1:0] v);
        case (idx)
            REG_MODE:      law = v[2:0];
            REG_GAIN_P:    kp = 64'(v[GAIN_W-1:0]);
            REG_GAIN_I:    ki = 64'(v[GAIN_W-1:0]);
            REG_GAIN_D:    kd = 64'(v[GAIN_W-1:0]);
            REG_UPPER:     upper_bnd = longint'($signed(v));
            REG_LOWER:     lower_bnd = longint'($signed(v));
            REG_SEP_LIMIT: sep_lim = longint'(v[LIM_W-1:0]);
            REG_FULL_LIM:  full_lim = longint'(v[LIM_W-1:0]);
            default: ;
        endcase
    endfunction

    // one control step: new drive value and clip flag
    function automatic t_drive control_step(logic [DATA_W-1:0] sp);
        bit              sat, dummy, accumulate, separate, ramp, windup;
        longint          e, ae, y, iterm, den, inc;
        longint unsigned w;
        logic [2:0]      m;
        t_drive          res;
        sat = 1'b0;
        dummy = 1'b0;
        e = clip_word(longint'($signed(sp)) - last_drive, dummy);
        m = (law > LAW_ALL) ? LAW_ALL : law;
        if (m == LAW_INCREMENTAL) begin
            inc = scale(e - err_prev2, kp) + scale(e, ki)
                + scale(e - 2 * err_prev2 + err_prev, kd);
            y = clip_word(last_drive + inc, sat);
            err_prev = err_prev2;
            err_prev2 = e;
        end else begin
            ae = e < 0 ? -e : e;
            separate = m >= LAW_SEPARATION;
            ramp = (m == LAW_RAMP) || (m == LAW_ALL);
            windup = (m == LAW_ANTIWINDUP) || (m == LAW_ALL);
            accumulate = 1'b1;
            w = 64'h1 << FRAC_W;
            if (separate && ae > sep_lim) begin
                w = 0;
                accumulate = 1'b0;
            end else if (ramp && ae >= full_lim) begin
                den = sep_lim - full_lim;
                if (den > 0)
                    w = (64'(sep_lim - ae) << FRAC_W) / 64'(den);
            end
            // anti-windup: only errors that pull back from the bound integrate
            if (accumulate && windup) begin
                if (last_drive > upper_bnd)
                    accumulate = e < 0;
                else if (last_drive < lower_bnd)
                    accumulate = e > 0;
            end
            if (accumulate)
                integ = clip_word(integ + e, sat);
            iterm = scale(scale(integ, ki), w);
            y = clip_word(scale(e, kp) + iterm + scale(e - err_prev, kd), sat);
            err_prev = e;
        end
        last_drive = y;
        res.drive = y[DATA_W-1:0];
        res.sat = sat;
        return res;
    endfunction

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls and checking against the oldest expectation
    always @(posedge i_clk) begin
        t_drive exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected item: drive %h sat %b", m_axis_tdata, m_axis_tuser);
            end else begin
                exp_r = drive_q.pop_front();
                if (exp_r.drive !== m_axis_tdata || exp_r.sat !== m_axis_tuser) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: drive exp %h got %h, sat exp %b got %b",
                                 exp_r.drive, m_axis_tdata, exp_r.sat, m_axis_tuser);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= idle_out);
    end

    // send one setpoint, predict its result once accepted
    task automatic send_setpoint(logic [DATA_W-1:0] sp, bit typed, t_drive typed_res);
        t_drive pred;
        // a preceding register write ends here
        i_cfg_we <= 1'b0;
        if ($urandom_range(99) < idle_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_in) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sp;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = control_step(sp);
        drive_q.push_back(typed ? typed_res : pred);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high into back-to-back writes; the next item or drain lowers it
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        shadow_reg(idx, v);
    endtask

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(4))
            0: return '0;
            1: return 32'hff_ffff;
            2: return 32'($urandom_range(65536));
            default: return 32'($urandom_range(32'hff_ffff));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_level();
        case ($urandom_range(4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(2 ** 26)) - 2 ** 25);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(4))
            0: return '0;
            1: return 32'h7fff_ffff;
            2: return $urandom() >> 1;
            default: return 32'($urandom_range(2 ** 26));
        endcase
    endfunction

    // setpoints mostly near the current drive so the loop stays in range
    function automatic logic [DATA_W-1:0] pick_setpoint();
        if ($urandom_range(3) == 0)
            return $urandom();
        return last_drive[DATA_W-1:0] + 32'($signed($urandom_range(2 ** 25)) - 2 ** 24);
    endfunction

    t_row   rows[$];
    t_drive zero_res;

    function automatic void add_cfg(t_reg_idx idx, logic [DATA_W-1:0] v);
        t_row r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.value = v;
        r.typed = 1'b0;
        r.typed_res = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_sp(logic [DATA_W-1:0] v, bit typed = 1'b0,
                                   t_drive res = '0);
        t_row r;
        r.is_cfg = 1'b0;
        r.idx = REG_MODE;
        r.value = v;
        r.typed = typed;
        r.typed_res = res;
        rows.push_back(r);
    endfunction

    // stimulus
    initial begin
        logic [DATA_W-1:0] sep_v;
        bit                prev_cfg;
        load_defaults();
        zero_res = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: extremes, every law, separation, equal limits, spare modes
        add_sp(32'h0, 1'b1, zero_res);
        add_sp(32'h00c8_0000);
        add_sp(32'h00b4_0000);
        add_sp(32'h7fff_ffff);
        add_sp(32'h8000_0000);
        add_cfg(REG_MODE, LAW_POSITIONAL);
        add_sp(32'h0064_0000);
        add_cfg(REG_MODE, LAW_INCREMENTAL);
        add_sp(32'h7fff_ffff);
        add_sp(32'h8000_0000);
        add_cfg(REG_MODE, LAW_SEPARATION);
        add_sp(32'h012c_0000);
        add_cfg(REG_MODE, LAW_ANTIWINDUP);
        add_cfg(REG_UPPER, 32'h0);
        add_cfg(REG_LOWER, 32'h0);
        add_sp(32'h0032_0000);
        add_sp(32'hffce_0000);
        add_cfg(REG_MODE, LAW_RAMP);
        add_cfg(REG_SEP_LIMIT, 32'h0064_0000);
        add_cfg(REG_FULL_LIM, 32'h0064_0000);
        add_sp(32'h0064_0000);
        add_cfg(REG_MODE, LAW_SPARE_B);
        add_sp(32'h000a_0000);
        add_cfg(REG_MODE, LAW_SPARE_A);
        add_cfg(REG_GAIN_P, 32'hff_ffff);
        add_cfg(REG_GAIN_I, 32'hff_ffff);
        add_cfg(REG_GAIN_D, 32'h0);
        add_sp(32'h7fff_ffff);
        add_sp(32'h8000_0000);

        idle_in = 19;
        idle_out = 84;
        prev_cfg = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (!prev_cfg) drain();
                write_reg(rows[i].idx, rows[i].value);
            end else begin
                send_setpoint(rows[i].value, rows[i].typed, rows[i].typed_res);
            end
            prev_cfg = rows[i].is_cfg;
        end

        // random phases, each with a fresh register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES / 3) begin
                idle_in = 84;
                idle_out = 19;
            end else if (ph == 2 * PHASES / 3) begin
                idle_in = 0;
                idle_out = 0;
            end
            drain();
            write_reg(REG_MODE, 32'($urandom_range(7)));
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            write_reg(REG_UPPER, pick_level());
            write_reg(REG_LOWER, pick_level());
            sep_v = pick_limit();
            write_reg(REG_SEP_LIMIT, sep_v);
            // often a ramp below the separation limit, sometimes equal or above
            case ($urandom_range(3))
                0: write_reg(REG_FULL_LIM, sep_v);
                1: write_reg(REG_FULL_LIM, pick_limit());
                default: write_reg(REG_FULL_LIM, 32'($urandom_range(sep_v)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_setpoint(pick_setpoint(), 1'b0, zero_res);
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
